// ===== rtl/core/sfeob_pkg.sv =====
`default_nettype none
package sfeob_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [1:0] OP_START   = 2'd0;
   localparam logic [1:0] OP_PAYLOAD = 2'd1;
   localparam logic [1:0] OP_END     = 2'd2;

   localparam logic [1:0] KIND_START     = 2'd0;
   localparam logic [1:0] KIND_GROUP     = 2'd1;
   localparam logic [1:0] KIND_END_FLUSH = 2'd2;
   localparam logic [1:0] KIND_END_BARE  = 2'd3;

   localparam logic [7:0] CH_START     = 8'h23;
   localparam logic [7:0] CH_ADDR_BASE = 8'h61;
   localparam logic [7:0] CH_OFFSET    = 8'h3d;
   localparam logic [7:0] CH_CR        = 8'h0d;

   localparam logic [2:0] STEP_FIRST    = 3'd0;
   localparam logic [2:0] STEP_SUM_HI   = 3'd4;
   localparam logic [2:0] STEP_SUM_LO   = 3'd5;
   localparam logic [2:0] STEP_CR       = 3'd6;
   localparam logic [2:0] STEP_START_LAST = 3'd2;
   localparam logic [2:0] STEP_GROUP_LAST = 3'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [23:0] data;
   } job_type;

endpackage
`default_nettype wire

// ===== rtl/core/serial_frame_encoder_offset_base64_core.sv =====
`default_nettype none
// Frame encoder: a start beat yields '#', 'a'+address and the command; payload
// bytes are packed three to four characters (61 plus six bits each); an end beat
// flushes any partial group, then sends two checksum characters and CR with
// rsp_frame_end set. The front accepts one beat per cycle while its job queue
// (QueueDepth entries) has room; the back emits one character per cycle unless
// rsp_stall holds the output, so the character output port sets the rate: a
// payload byte costs 4/3 characters on average, a start beat 3 characters, an
// end beat 3 or 7. A beat passes the queue, the job and the output registers.
module serial_frame_encoder_offset_base64_core #(
   parameter int QueueDepth = sfeob_pkg::QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_operation,
   input  wire logic [7:0] req_address,
   input  wire logic [7:0] req_command,
   input  wire logic [7:0] req_payload_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_tx_char,
   output logic            rsp_frame_end
);
   import sfeob_pkg::*;

   logic    push_valid;
   job_type push_job;
   logic    q_full;
   logic    q_valid;
   job_type q_job;
   logic    pop;

   sfeob_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_address      (req_address),
      .req_command      (req_command),
      .req_payload_byte (req_payload_byte),
      .q_full           (q_full),
      .push_valid       (push_valid),
      .push_job         (push_job)
   );

   sfeob_queue #(
      .QueueDepth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .q_full     (q_full),
      .q_valid    (q_valid),
      .q_job      (q_job),
      .pop        (pop)
   );

   sfeob_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_job         (q_job),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_tx_char   (rsp_tx_char),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule
`default_nettype wire

// ===== rtl/core/sfeob_front.sv =====
`default_nettype none
module sfeob_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [1:0]        req_operation,
   input  wire logic [7:0]        req_address,
   input  wire logic [7:0]        req_command,
   input  wire logic [7:0]        req_payload_byte,
   input  wire logic              q_full,
   output logic                   push_valid,
   output sfeob_pkg::job_type     push_job
);
   import sfeob_pkg::*;

   logic [7:0] g0_ff, g0_in;
   logic [7:0] g1_ff, g1_in;
   logic [1:0] fill_ff, fill_in;
   logic       in_frame_ff, in_frame_in;
   logic       accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   always_comb begin
      g0_in       = g0_ff;
      g1_in       = g1_ff;
      fill_in     = fill_ff;
      in_frame_in = in_frame_ff;
      push_valid  = 1'b0;
      push_job    = '{kind: KIND_START, data: {req_address, req_command, 8'h00}};
      if (accept) begin
         case (req_operation)
            OP_START: begin
               g0_in       = 8'h00;
               g1_in       = 8'h00;
               fill_in     = 2'd0;
               in_frame_in = 1'b1;
               push_valid  = 1'b1;
            end
            OP_PAYLOAD: begin
               if (in_frame_ff) begin
                  if (fill_ff == 2'd2) begin
                     push_valid = 1'b1;
                     push_job   = '{kind: KIND_GROUP, data: {g0_ff, g1_ff, req_payload_byte}};
                     g0_in      = 8'h00;
                     g1_in      = 8'h00;
                     fill_in    = 2'd0;
                  end else begin
                     if (fill_ff == 2'd0) begin
                        g0_in = req_payload_byte;
                     end else begin
                        g1_in = req_payload_byte;
                     end
                     fill_in = fill_ff + 2'd1;
                  end
               end
            end
            OP_END: begin
               if (in_frame_ff) begin
                  push_valid    = 1'b1;
                  push_job.kind = (fill_ff != 2'd0) ? KIND_END_FLUSH : KIND_END_BARE;
                  push_job.data = {g0_ff, (fill_ff == 2'd2) ? g1_ff : 8'h00, 8'h00};
                  g0_in         = 8'h00;
                  g1_in         = 8'h00;
                  fill_in       = 2'd0;
                  in_frame_in   = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      g0_ff <= g0_in;
      g1_ff <= g1_in;
      if (reset) begin
         fill_ff     <= 2'd0;
         in_frame_ff <= 1'b0;
      end else begin
         fill_ff     <= fill_in;
         in_frame_ff <= in_frame_in;
      end
   end

`ifndef SYNTHESIS
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff != 2'd3) else $error("group fill out of range");
   a_fill_needs_frame: assert property (@(posedge clock) disable iff (reset)
      (fill_ff != 2'd0) |-> in_frame_ff) else $error("partial group outside frame");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/sfeob_queue.sv =====
`default_nettype none
module sfeob_queue #(
   parameter int QueueDepth = sfeob_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   input  wire sfeob_pkg::job_type push_job,
   output logic                   q_full,
   output logic                   q_valid,
   output sfeob_pkg::job_type     q_job,
   input  wire logic              pop
);
   import sfeob_pkg::*;

   localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntW = $clog2(QueueDepth + 1);

   job_type           slot_ff [QueueDepth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign q_full  = (count_ff == CntW'(QueueDepth));
   assign q_valid = (count_ff != '0);
   assign q_job   = slot_ff[rd_ptr_ff];
   assign do_push = push_valid && !q_full;
   assign do_pop  = pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(QueueDepth)) else $error("queue count overflow");
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      !(push_valid && q_full)) else $error("push into full queue");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/sfeob_back.sv =====
`default_nettype none
module sfeob_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   input  wire sfeob_pkg::job_type q_job,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [7:0]              rsp_tx_char,
   output logic                    rsp_frame_end
);
   import sfeob_pkg::*;

   job_type     job_ff, job_in;
   logic        job_valid_ff, job_valid_in;
   logic [2:0]  step_ff, step_in;
   logic [11:0] sum_ff, sum_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_char_ff, out_char_in;
   logic        out_end_ff, out_end_in;
   logic        adv;
   logic        emit;
   logic        last;
   logic [2:0]  last_step;
   logic [5:0]  slice;
   logic [7:0]  ch;

   assign adv  = !out_valid_ff || !rsp_stall;
   assign emit = job_valid_ff && adv;

   always_comb begin
      case (job_ff.kind)
         KIND_START: last_step = STEP_START_LAST;
         KIND_GROUP: last_step = STEP_GROUP_LAST;
         default:    last_step = STEP_CR;
      endcase
   end

   assign last = (step_ff == last_step);
   assign pop  = q_valid && (!job_valid_ff || (emit && last));

   always_comb begin
      case (step_ff[1:0])
         2'd0:    slice = job_ff.data[23:18];
         2'd1:    slice = job_ff.data[17:12];
         2'd2:    slice = job_ff.data[11:6];
         default: slice = job_ff.data[5:0];
      endcase
   end

   always_comb begin
      ch = CH_OFFSET + {2'b00, slice};
      if (job_ff.kind == KIND_START) begin
         case (step_ff)
            STEP_FIRST: ch = CH_START;
            3'd1:       ch = CH_ADDR_BASE + job_ff.data[23:16];
            default:    ch = job_ff.data[15:8];
         endcase
      end else begin
         case (step_ff)
            STEP_SUM_HI: ch = CH_OFFSET + {2'b00, sum_ff[11:6]};
            STEP_SUM_LO: ch = CH_OFFSET + {2'b00, sum_ff[5:0]};
            STEP_CR:     ch = CH_CR;
            default:     ch = CH_OFFSET + {2'b00, slice};
         endcase
      end
   end

   always_comb begin
      job_in       = job_ff;
      job_valid_in = job_valid_ff;
      step_in      = step_ff;
      sum_in       = sum_ff;
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_end_in   = out_end_ff;
      if (adv) begin
         out_valid_in = job_valid_ff;
      end
      if (emit) begin
         out_char_in = ch;
         out_end_in  = (job_ff.kind != KIND_START) && (job_ff.kind != KIND_GROUP)
                       && (step_ff == STEP_CR);
         if (job_ff.kind == KIND_START && step_ff == STEP_FIRST) begin
            sum_in = {4'h0, ch};
         end else if (step_ff < STEP_SUM_HI) begin
            sum_in = sum_ff + {4'h0, ch};
         end
         step_in = step_ff + 3'd1;
         if (last) begin
            job_valid_in = 1'b0;
         end
      end
      if (pop) begin
         job_in       = q_job;
         job_valid_in = 1'b1;
         step_in      = (q_job.kind == KIND_END_BARE) ? STEP_SUM_HI : STEP_FIRST;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      sum_ff      <= sum_in;
      out_char_ff <= out_char_in;
      out_end_ff  <= out_end_in;
      if (reset) begin
         job_valid_ff <= 1'b0;
         step_ff      <= STEP_FIRST;
         out_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_tx_char   = out_char_ff;
   assign rsp_frame_end = out_end_ff;

`ifndef SYNTHESIS
   a_end_is_cr: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_end_ff) |-> (out_char_ff == CH_CR))
      else $error("frame end on a character other than CR");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff |-> (step_ff <= STEP_CR)) else $error("step out of range");
`endif

endmodule
`default_nettype wire
